[design/fepm_pkg.sv]
`default_nettype none

package fepm_pkg;

   localparam int DEF_SLOTS     = 8;
   localparam int DEF_TICK_BITS = 16;

   // Gain is a percentage; the divide by one hundred uses a reciprocal.
   localparam int GAIN_FULL    = 100;
   localparam int RECIP_100    = 41943;
   localparam int RECIP_SHIFT  = 22;
   localparam int DIV_STEPS    = 32;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_STAGE  = 3'd1,
      OP_COMMIT = 3'd2,
      OP_REMOVE = 3'd3,
      OP_START  = 3'd4,
      OP_STOP   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      KIND_CONSTANT = 2'd0,
      KIND_SPRING   = 2'd1,
      KIND_DAMPER   = 2'd2,
      KIND_INERTIA  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef struct packed {
      kind_type           kind;
      logic [15:0]        duration;
      logic [15:0]        attack;
      logic [15:0]        fade;
      logic [15:0]        repeat_ivl;
      logic [6:0]         gain;
      logic signed [15:0] strength;
      logic signed [15:0] center;
      logic signed [15:0] deadband;
   } slot_cfg_type;

   typedef struct packed {
      logic capture;
      logic idx_clr;
      logic idx_inc;
      logic exec;
      logic commit_wr;
      logic commit_full;
      logic eval;
      logic mul;
      logic div_load;
      logic div_step;
      logic gain;
      logic recip;
      logic acc;
      logic rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic is_commit;
      logic idx_last;
      logic cur_active;
      logic slot_live;
      logic need_div;
      logic div_done;
      logic rsp_free;
   } ctl_status_type;

   function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
      logic signed [15:0] r;
      if (v > 36'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -36'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [15:0] clamp_u16(input logic signed [16:0] v);
      logic [15:0] r;
      if (v[16]) begin
         r = 16'd0;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[design/force_effect_pool_mixer.sv]
`default_nettype none

// Force-feedback effect pool with SLOTS slots, taking one command beat at a
// time: stage timing, commit (first free slot, or a full status), remove,
// start, stop and tick. Every command returns exactly one result beat. A
// tick walks the slots one by one, reading and evaluating each; a running
// slot adds a multiply, gain and divide-by-hundred chain, plus the shared
// restoring divider when a constant effect sits on an attack or fade ramp.
// A commit scans the active flags one slot per cycle. The next command is
// taken while the last result still waits in the output register.

module force_effect_pool_mixer import fepm_pkg::*; #(
   parameter int SLOTS     = DEF_SLOTS,
   parameter int TICK_BITS = DEF_TICK_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_op,
   input  wire logic [2:0]         req_slot,
   input  wire logic [1:0]         req_effect_kind,
   input  wire logic signed [16:0] req_word_a,
   input  wire logic signed [16:0] req_word_b,
   input  wire logic signed [16:0] req_word_c,
   input  wire logic [15:0]        req_word_d,
   input  wire logic [6:0]         req_gain_pct,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [14:0]             rsp_force_mag,
   output logic                    rsp_turn_right,
   output logic [3:0]              rsp_slot_out,
   output logic [1:0]              rsp_status
);

   ctl_cmd_type    cmd;
   ctl_status_type sts;

   // The controller sequences the walk; the datapath holds all slot state.
   fepm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fepm_datapath #(
      .SLOTS     (SLOTS),
      .TICK_BITS (TICK_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_op),
      .req_slot        (req_slot),
      .req_effect_kind (req_effect_kind),
      .req_word_a      (req_word_a),
      .req_word_b      (req_word_b),
      .req_word_c      (req_word_c),
      .req_word_d      (req_word_d),
      .req_gain_pct    (req_gain_pct),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_force_mag   (rsp_force_mag),
      .rsp_turn_right  (rsp_turn_right),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_status      (rsp_status)
   );

   // A result is only written into a free output register.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("result loaded over a waiting result");

   // A commit only ever lands on a slot that is free.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_wr |-> !sts.cur_active)
      else $error("commit into an active slot");

   // A negative net force always has a nonzero magnitude.
   a_dir_mag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_turn_right) |-> (rsp_force_mag != 15'd0))
      else $error("direction set with zero magnitude");

endmodule

`default_nettype wire

[design/fepm_ctrl.sv]
`default_nettype none

module fepm_ctrl import fepm_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire ctl_status_type sts,
   output ctl_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISP, S_SCAN, S_RD, S_EVAL, S_MUL, S_DIVL, S_DIV,
      S_GAIN, S_RECIP, S_ACC, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = S_DISP;
            end
         end
         S_DISP: begin
            if (sts.is_tick) begin
               state_in = S_RD;
            end else if (sts.is_commit) begin
               state_in = S_SCAN;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (!sts.cur_active) begin
               cmd.commit_wr = 1'b1;
               state_in      = S_DONE;
            end else if (sts.idx_last) begin
               cmd.commit_full = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_RD: state_in = S_EVAL;
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.slot_live) begin
               state_in = S_MUL;
            end else if (sts.idx_last) begin
               state_in = S_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_RD;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = sts.need_div ? S_DIVL : S_GAIN;
         end
         S_DIVL: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            cmd.gain = 1'b1;
            state_in = S_RECIP;
         end
         S_RECIP: begin
            cmd.recip = 1'b1;
            state_in  = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (sts.idx_last) begin
               state_in = S_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_RD;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

[design/fepm_datapath.sv]
`default_nettype none

module fepm_datapath import fepm_pkg::*; #(
   parameter int SLOTS     = DEF_SLOTS,
   parameter int TICK_BITS = DEF_TICK_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctl_cmd_type        cmd,
   output ctl_status_type          sts,
   input  wire logic [2:0]         req_op,
   input  wire logic [2:0]         req_slot,
   input  wire logic [1:0]         req_effect_kind,
   input  wire logic signed [16:0] req_word_a,
   input  wire logic signed [16:0] req_word_b,
   input  wire logic signed [16:0] req_word_c,
   input  wire logic [15:0]        req_word_d,
   input  wire logic [6:0]         req_gain_pct,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [14:0]             rsp_force_mag,
   output logic                    rsp_turn_right,
   output logic [3:0]              rsp_slot_out,
   output logic [1:0]              rsp_status
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ACC_W = 16 + IDX_W + 1;
   localparam int CW    = ((TICK_BITS > 18) ? TICK_BITS : 18) + 1;

   // Captured request.
   logic [2:0]         op_ff;
   logic [2:0]         slot_ff;
   logic [1:0]         kind_ff;
   logic signed [16:0] wa_ff, wb_ff, wc_ff;
   logic [15:0]        wd_ff;
   logic [6:0]         gain_ff;

   logic [15:0] stg_dur_ff, stg_att_ff, stg_fade_ff, stg_rep_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [SLOTS-1:0] active_ff, running_ff;

   slot_cfg_type         slot_mem [SLOTS];
   logic [TICK_BITS-1:0] tick_mem [SLOTS];
   slot_cfg_type         rd_cfg_ff;
   logic [TICK_BITS-1:0] rd_tick_ff;

   logic                    tick_wr;
   logic [TICK_BITS-1:0]    tick_wr_data;
   slot_cfg_type            new_cfg;

   logic [3:0]  res_slot_ff;
   logic [1:0]  res_status_ff;

   logic signed [15:0] mul_a_ff;
   logic signed [18:0] mul_b_ff;
   logic               const_ff;
   logic [15:0]        den_ff;
   logic signed [34:0] prod_ff;
   logic [16:0]        rem_ff;
   logic [31:0]        dvd_ff;
   logic [4:0]         dcnt_ff;
   logic signed [23:0] gprod_ff;
   logic               gneg_ff;
   logic [21:0]        gm_ff;
   logic [37:0]        recip_ff;
   logic signed [ACC_W-1:0] acc_ff;

   logic rsp_valid_ff;
   logic [14:0] rsp_mag_ff;
   logic rsp_right_ff;
   logic [3:0] rsp_slot_ff;
   logic [1:0] rsp_status_ff;

   // ---------------- slot index of remove, start and stop
   logic             sel_in_range;
   logic [IDX_W-1:0] sel_idx;
   logic [IDX_W+2:0] sel_ext;
   assign sel_ext      = (IDX_W + 3)'(slot_ff);
   assign sel_in_range = (32'(slot_ff) < SLOTS);
   assign sel_idx      = sel_ext[IDX_W-1:0];

   // ---------------- envelope and condition operands
   logic [CW-1:0] te, ae, ad, fe, de, te1, tend, xe;
   logic [TICK_BITS-1:0] t1;
   logic [15:0]   env_num, env_den;
   logic signed [16:0] metric;
   logic signed [18:0] lo, hi, m19, diff;
   logic run_set, run_clr;

   always_comb begin
      te  = CW'(rd_tick_ff);
      ae  = CW'(rd_cfg_ff.attack);
      de  = CW'(rd_cfg_ff.duration);
      fe  = CW'(rd_cfg_ff.fade);
      ad  = ae + de;
      xe  = te - ad;
      if (rd_cfg_ff.duration == 16'd0 || (te >= ae && te < ad)) begin
         env_num = 16'd1;
         env_den = 16'd1;
      end else if (te < ae) begin
         env_num = te[15:0];
         env_den = rd_cfg_ff.attack;
      end else if (rd_cfg_ff.fade != 16'd0 && xe < fe) begin
         env_num = 16'(fe - xe);
         env_den = rd_cfg_ff.fade;
      end else begin
         env_num = 16'd0;
         env_den = 16'd1;
      end

      unique case (rd_cfg_ff.kind)
         KIND_SPRING: metric = wa_ff;
         KIND_DAMPER: metric = wb_ff;
         default:     metric = wc_ff;
      endcase
      m19 = 19'(metric);
      lo  = 19'(rd_cfg_ff.center) - 19'(rd_cfg_ff.deadband);
      hi  = 19'(rd_cfg_ff.center) + 19'(rd_cfg_ff.deadband);
      if (m19 < lo) begin
         diff = m19 - lo;
      end else if (m19 > hi) begin
         diff = m19 - hi;
      end else begin
         diff = '0;
      end

      // Timer advance for the slot being visited.
      t1      = rd_tick_ff + TICK_BITS'(1);
      te1     = CW'(t1);
      tend    = ae + fe + de;
      run_set = 1'b0;
      run_clr = 1'b0;
      if (active_ff[idx_ff] && !running_ff[idx_ff]) begin
         run_set = (te1 == CW'(rd_cfg_ff.repeat_ivl));
      end else if (rd_cfg_ff.duration != 16'd0 && running_ff[idx_ff]
                   && active_ff[idx_ff]) begin
         run_clr = (te1 >= tend);
      end
   end

   // ---------------- slot memories
   always_comb begin
      new_cfg.kind       = kind_type'(kind_ff);
      new_cfg.duration   = stg_dur_ff;
      new_cfg.attack     = stg_att_ff;
      new_cfg.fade       = stg_fade_ff;
      new_cfg.repeat_ivl = stg_rep_ff;
      new_cfg.gain       = (gain_ff > 7'(GAIN_FULL)) ? 7'(GAIN_FULL) : gain_ff;
      new_cfg.strength   = sat16(36'(wa_ff));
      new_cfg.center     = sat16(36'(wb_ff));
      new_cfg.deadband   = sat16(36'(wc_ff));
      tick_wr            = cmd.commit_wr || cmd.eval;
      tick_wr_data       = (cmd.commit_wr || run_set || run_clr) ? '0 : t1;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit_wr) begin
         slot_mem[idx_ff] <= new_cfg;
      end
      if (tick_wr) begin
         tick_mem[idx_ff] <= tick_wr_data;
      end
      rd_cfg_ff  <= slot_mem[idx_ff];
      rd_tick_ff <= tick_mem[idx_ff];
   end

   // ---------------- control state: flags, index, staged timing
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         running_ff  <= '0;
         idx_ff      <= '0;
         stg_dur_ff  <= '0;
         stg_att_ff  <= '0;
         stg_fade_ff <= '0;
         stg_rep_ff  <= '0;
      end else begin
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.commit_wr) begin
            active_ff[idx_ff]  <= 1'b1;
            running_ff[idx_ff] <= 1'b0;
         end
         if (cmd.eval) begin
            if (run_set) begin
               running_ff[idx_ff] <= 1'b1;
            end else if (run_clr) begin
               running_ff[idx_ff] <= 1'b0;
            end
         end
         if (cmd.exec) begin
            unique case (op_ff)
               OP_STAGE: begin
                  stg_dur_ff  <= clamp_u16(wa_ff);
                  stg_att_ff  <= clamp_u16(wb_ff);
                  stg_fade_ff <= clamp_u16(wc_ff);
                  stg_rep_ff  <= wd_ff;
               end
               OP_REMOVE: begin
                  if (sel_in_range && active_ff[sel_idx]) begin
                     active_ff[sel_idx] <= 1'b0;
                  end
               end
               OP_START: begin
                  if (sel_in_range && active_ff[sel_idx]) begin
                     running_ff[sel_idx] <= 1'b1;
                  end
               end
               OP_STOP: begin
                  if (sel_in_range && active_ff[sel_idx]) begin
                     running_ff[sel_idx] <= 1'b0;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Gain is read from the slot entry still held in the read register.
   logic [6:0] gain_slot;
   assign gain_slot = rd_cfg_ff.gain;

   // ---------------- divider step
   logic [34:0] prod_abs;
   logic [16:0] div_sh, div_rem;
   logic        div_bit;
   always_comb begin
      prod_abs = prod_ff[34] ? 35'(-prod_ff) : 35'(prod_ff);
      div_sh   = {rem_ff[15:0], dvd_ff[31]};
      div_bit  = (div_sh >= {1'b0, den_ff});
      div_rem  = div_bit ? (div_sh - {1'b0, den_ff}) : div_sh;
   end

   // ---------------- slot force before saturation
   logic [31:0]        mag_q;
   logic signed [35:0] mq, force_raw;
   always_comb begin
      mag_q = (den_ff != 16'd1) ? dvd_ff : prod_abs[31:0];
      mq    = $signed({4'b0, mag_q});
      if (const_ff) begin
         force_raw = prod_ff[34] ? mq : -mq;
      end else begin
         force_raw = 36'(prod_ff);
      end
   end

   // ---------------- divide by one hundred with one correction
   logic [23:0] gprod_mag;
   logic [21:0] gabs;
   logic [15:0] q0, qc;
   logic [23:0] rr;
   logic signed [ACC_W-1:0] contrib;
   always_comb begin
      gprod_mag = gprod_ff[23] ? 24'(-gprod_ff) : 24'(gprod_ff);
      gabs      = gprod_mag[21:0];
      q0        = recip_ff[RECIP_SHIFT+15:RECIP_SHIFT];
      rr        = 24'(gm_ff) - 24'(q0) * 24'(GAIN_FULL);
      qc        = (rr >= 24'(GAIN_FULL)) ? q0 + 16'd1 : q0;
      contrib   = gneg_ff ? -$signed(ACC_W'(qc)) : $signed(ACC_W'(qc));
   end

   // ---------------- request capture and command results
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff         <= req_op;
         slot_ff       <= req_slot;
         kind_ff       <= req_effect_kind;
         wa_ff         <= req_word_a;
         wb_ff         <= req_word_b;
         wc_ff         <= req_word_c;
         wd_ff         <= req_word_d;
         gain_ff       <= req_gain_pct;
         res_slot_ff   <= '0;
         res_status_ff <= ST_OK;
         acc_ff        <= '0;
      end
      if (cmd.exec && (op_ff == OP_REMOVE || op_ff == OP_START || op_ff == OP_STOP)
          && !(sel_in_range && active_ff[sel_idx])) begin
         res_status_ff <= ST_BAD;
      end
      if (cmd.commit_wr) begin
         res_slot_ff <= 4'(idx_ff);
      end
      if (cmd.commit_full) begin
         res_slot_ff   <= 4'(SLOTS);
         res_status_ff <= ST_FULL;
      end

      // Force arithmetic.
      if (cmd.eval) begin
         mul_a_ff <= rd_cfg_ff.strength;
         const_ff <= (rd_cfg_ff.kind == KIND_CONSTANT);
         if (rd_cfg_ff.kind == KIND_CONSTANT) begin
            mul_b_ff <= $signed(19'(env_num));
            den_ff   <= env_den;
         end else begin
            mul_b_ff <= diff;
            den_ff   <= 16'd1;
         end
      end
      if (cmd.mul) begin
         prod_ff <= 35'(mul_a_ff) * 35'(mul_b_ff);
      end
      if (cmd.div_load) begin
         rem_ff  <= '0;
         dvd_ff  <= prod_abs[31:0];
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= div_rem;
         dvd_ff  <= {dvd_ff[30:0], div_bit};
         dcnt_ff <= dcnt_ff + 5'd1;
      end
      if (cmd.gain) begin
         gprod_ff <= 24'(sat16(force_raw)) * $signed(24'(gain_slot));
      end
      if (cmd.recip) begin
         gneg_ff  <= gprod_ff[23];
         gm_ff    <= gabs;
         recip_ff <= 38'(gabs) * 38'(RECIP_100);
      end
      if (cmd.acc) begin
         acc_ff <= acc_ff + contrib;
      end
   end

   // ---------------- result register
   logic [ACC_W-1:0] net_abs;
   logic [14:0]      net_mag;
   always_comb begin
      net_abs = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      net_mag = (net_abs > ACC_W'(32767)) ? 15'h7FFF : net_abs[14:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         if (op_ff == OP_TICK) begin
            rsp_mag_ff    <= net_mag;
            rsp_right_ff  <= acc_ff[ACC_W-1];
            rsp_slot_ff   <= '0;
            rsp_status_ff <= ST_OK;
         end else begin
            rsp_mag_ff    <= '0;
            rsp_right_ff  <= 1'b0;
            rsp_slot_ff   <= res_slot_ff;
            rsp_status_ff <= res_status_ff;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_force_mag  = rsp_mag_ff;
   assign rsp_turn_right = rsp_right_ff;
   assign rsp_slot_out   = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;

   always_comb begin
      sts.is_tick    = (op_ff == OP_TICK);
      sts.is_commit  = (op_ff == OP_COMMIT);
      sts.idx_last   = (idx_ff == IDX_W'(SLOTS - 1));
      sts.cur_active = active_ff[idx_ff];
      sts.slot_live  = active_ff[idx_ff] && running_ff[idx_ff];
      sts.need_div   = const_ff && (den_ff != 16'd1);
      sts.div_done   = (dcnt_ff == 5'(DIV_STEPS - 1));
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule

`default_nettype wire
